// File: hw/rtl/bdq_pkg.sv
// bounded deque package: operation codes, status codes, default depth
// and the command and status structs between controller and datapath
// no dependencies
package bdq_pkg;

  // default number of entries
  localparam int BDQ_DEPTH = 16;

  // operation codes carried on func
  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_POP_BACK   = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_PUSH_FRONT = 2'd3
  } op_t;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic start;  // input beat accepted: update pointers, touch memory
    logic load;   // move pending result into output register
  } bdq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } bdq_stat_t;

endpackage

// File: hw/rtl/bdq_ctrl.sv
// bounded deque controller: accepts an input beat, then waits for the
// memory read and a free output register before returning to idle
// depends on bdq_pkg
module bdq_ctrl import bdq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bdq_stat_t stat,
  output bdq_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // handshake and commands
  always_comb begin
    in_ready  = (state == S_IDLE);
    cmd.start = in_valid && (state == S_IDLE);
    cmd.load  = (state == S_EXEC) && stat.out_free;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/bdq_datapath.sv
// bounded deque datapath: circular buffer memory, head/tail pointers,
// occupancy counter, pending result and output register
// depends on bdq_pkg
module bdq_datapath import bdq_pkg::*; #(
  parameter int DEPTH = BDQ_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  bdq_cmd_t   cmd,
  output bdq_stat_t  stat,
  input  logic [1:0] func,
  input  logic [7:0] value,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] data,
  output logic [1:0] status,
  output logic [4:0] occupancy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head, tail;
  logic [AW-1:0] head_next, tail_next;
  logic [CW-1:0] count, count_next;
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data;

  logic          pend_pop;
  logic [1:0]    pend_status;
  logic [4:0]    pend_occ;

  logic          is_push, full, empty;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic [1:0]    status_next;

  // pointer neighbors with wrap at any depth
  always_comb begin
    head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
    head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
    tail_inc = (tail == AW'(DEPTH - 1)) ? '0 : tail + AW'(1);
    tail_dec = (tail == '0) ? AW'(DEPTH - 1) : tail - AW'(1);
  end

  // operation decode
  always_comb begin
    is_push     = (func == OP_PUSH_BACK) || (func == OP_PUSH_FRONT);
    full        = (count == CW'(DEPTH));
    empty       = (count == '0);
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_addr     = tail;
    rd_addr     = head;
    status_next = ST_OK;
    if (is_push && full) begin
      status_next = ST_FULL;
    end else if (!is_push && empty) begin
      status_next = ST_EMPTY;
    end else begin
      case (func)
        OP_PUSH_BACK: begin
          wr_en      = 1'b1;
          wr_addr    = tail;
          tail_next  = tail_inc;
          count_next = count + CW'(1);
        end
        OP_POP_BACK: begin
          rd_en      = 1'b1;
          rd_addr    = tail_dec;
          tail_next  = tail_dec;
          count_next = count - CW'(1);
        end
        OP_POP_FRONT: begin
          rd_en      = 1'b1;
          rd_addr    = head;
          head_next  = head_inc;
          count_next = count - CW'(1);
        end
        OP_PUSH_FRONT: begin
          wr_en      = 1'b1;
          wr_addr    = head_dec;
          head_next  = head_dec;
          count_next = count + CW'(1);
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end
  end

  // buffer memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.start && wr_en) begin
      mem[wr_addr] <= value;
    end
    if (cmd.start && rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // pointers and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.start) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // pending result of the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pend_pop    <= rd_en;
      pend_status <= status_next;
      pend_occ    <= 5'(count_next);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data      <= pend_pop ? rd_data : 8'd0;
      status    <= pend_status;
      occupancy <= pend_occ;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("occupancy counter above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.start && is_push && !full |=> count == $past(count) + CW'(1))
    else $error("accepted push did not grow the counter");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == tail)
    else $error("empty deque with unequal pointers");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule

// File: hw/rtl/bounded_deque_top.sv
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    func, value
// out      out  out_valid / out_ready  data, status, occupancy
//
// each operation is an accept followed by the registered memory read
// the output register lets the next beat be accepted while a result waits
// a new beat's result loads only once the output register is free
// synchronous active-high reset empties the deque; entries are not cleared
// top level of the bounded deque; depends on bdq_pkg, bdq_ctrl, bdq_datapath
module bounded_deque_top import bdq_pkg::*; #(
  parameter int DEPTH = BDQ_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data,
  output logic [1:0] status,
  output logic [4:0] occupancy
);

  bdq_cmd_t  cmd;
  bdq_stat_t stat;

  // sequencing
  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and result path
  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .func      (func),
    .value     (value),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .data      (data),
    .status    (status),
    .occupancy (occupancy)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench for bounded_deque_top: directed and random deque operations under
// random idling and a long output stall, every result checked in order
// depends on bdq_pkg and the bounded deque rtl
module tb_top;
  import bdq_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic [4:0] occupancy;
  } deque_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] func = OP_PUSH_BACK;
  logic [7:0] value = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] data;
  logic [1:0] status;
  logic [4:0] occupancy;

  // shadow copy of the deque contents and pointers
  logic [7:0]  shadow_slots [BDQ_DEPTH];
  int unsigned shadow_head = 0;
  int unsigned shadow_tail = 0;
  int unsigned shadow_held = 0;

  deque_result_t pending_results [$];
  deque_result_t got_result;
  deque_result_t want_result;

  int unsigned ops_sent = 0;
  int unsigned results_seen = 0;
  int unsigned bad_results = 0;
  int unsigned seen_ok = 0;
  int unsigned seen_full = 0;
  int unsigned seen_empty = 0;
  int unsigned idle_pct = 0;
  bit          hold_req = 1'b0;

  bounded_deque_top #(
    .DEPTH(BDQ_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .data     (data),
    .status   (status),
    .occupancy(occupancy)
  );

  always #5 clk = ~clk;

  // apply one operation to the shadow deque and return what the block must report
  function automatic deque_result_t deque_apply(op_t op, logic [7:0] byte_in);
    deque_result_t r;
    bit            is_push;
    r = '0;
    r.status = ST_OK;
    is_push = (op == OP_PUSH_BACK) || (op == OP_PUSH_FRONT);
    if (is_push && shadow_held == BDQ_DEPTH) begin
      r.status = ST_FULL;
    end else if (!is_push && shadow_held == 0) begin
      r.status = ST_EMPTY;
    end else begin
      case (op)
        OP_PUSH_BACK: begin
          shadow_slots[shadow_tail] = byte_in;
          shadow_tail = (shadow_tail + 1) % BDQ_DEPTH;
          shadow_held++;
        end
        OP_POP_BACK: begin
          shadow_tail = (shadow_tail + BDQ_DEPTH - 1) % BDQ_DEPTH;
          r.data = shadow_slots[shadow_tail];
          shadow_held--;
        end
        OP_POP_FRONT: begin
          r.data = shadow_slots[shadow_head];
          shadow_head = (shadow_head + 1) % BDQ_DEPTH;
          shadow_held--;
        end
        default: begin
          shadow_head = (shadow_head + BDQ_DEPTH - 1) % BDQ_DEPTH;
          shadow_slots[shadow_head] = byte_in;
          shadow_held++;
        end
      endcase
    end
    r.occupancy = shadow_held[4:0];
    return r;
  endfunction

  // random operation, push chosen with the given percentage
  function automatic op_t pick_op(int unsigned push_pct);
    if ($urandom_range(0, 99) < push_pct) begin
      return ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    end
    return ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  // offer one beat, optionally after an idle burst, and record its expected result
  task automatic send_op(op_t op, logic [7:0] byte_in);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= op;
    value    <= byte_in;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(deque_apply(op, byte_in));
    ops_sent++;
  endtask

  // pops on an empty deque are refused at both ends
  task automatic test_empty_refusal();
    send_op(OP_POP_BACK, 8'hFF);
    send_op(OP_POP_FRONT, 8'h00);
  endtask

  // fill from both ends so the head wraps below slot zero, then push when full
  task automatic test_fill_and_full();
    logic [7:0] fill_byte;
    for (int i = 0; i < BDQ_DEPTH; i++) begin
      fill_byte = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      send_op((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, fill_byte);
    end
    send_op(OP_PUSH_BACK, 8'h5A);
    send_op(OP_PUSH_FRONT, 8'hA5);
  endtask

  // pops from each end of a full deque
  task automatic test_pop_both_ends();
    send_op(OP_POP_FRONT, 8'hAA);
    send_op(OP_POP_BACK, 8'h55);
    send_op(OP_POP_FRONT, 8'hFF);
    send_op(OP_POP_BACK, 8'h00);
  endtask

  // segments that lean toward filling, draining or neither, with varied idling
  task automatic test_random_mix(int unsigned n_ops);
    int unsigned done;
    int unsigned seg_len;
    int unsigned push_pct;
    done = 0;
    while (done < n_ops) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      for (int k = 0; k < seg_len && done < n_ops; k++) begin
        send_op(pick_op(push_pct), 8'($urandom_range(0, 255)));
        done++;
      end
    end
  endtask

  // receiver holds off for a long stretch while beats keep coming
  task automatic test_backpressure();
    idle_pct = 0;
    hold_req = 1'b1;
    repeat (40) send_op(pick_op(50), 8'($urandom_range(0, 255)));
  endtask

  // back to back beats with both sides always ready
  task automatic test_steady_stream();
    idle_pct = 0;
    repeat (100) send_op(pick_op(50), 8'($urandom_range(0, 255)));
  endtask

  // output side: long hold-off on request, random stall bursts otherwise
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_result = '{data: data, status: status, occupancy: occupancy};
      results_seen++;
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= SHOWN_ERRORS) begin
          $display("unexpected result beat: data %02h status %0d occupancy %0d",
                   data, status, occupancy);
        end
      end else begin
        want_result = pending_results.pop_front();
        case (want_result.status)
          ST_OK:   seen_ok++;
          ST_FULL: seen_full++;
          default: seen_empty++;
        endcase
        if (got_result.data !== want_result.data ||
            got_result.status !== want_result.status ||
            got_result.occupancy !== want_result.occupancy) begin
          bad_results++;
          if (bad_results <= SHOWN_ERRORS) begin
            $display("result %0d wrong: data exp %02h got %02h, status exp %0d got %0d,",
                     results_seen, want_result.data, got_result.data,
                     want_result.status, got_result.status);
            $display("  occupancy exp %0d got %0d",
                     want_result.occupancy, got_result.occupancy);
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // test sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 20;
    test_empty_refusal();
    test_fill_and_full();
    test_pop_both_ends();
    test_random_mix(1360);
    test_backpressure();
    test_steady_stream();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("ran %0d operations: %0d done, %0d refused as full, %0d refused as empty",
             ops_sent, seen_ok, seen_full, seen_empty);
    $display("checked %0d result beats, %0d with wrong fields or unexpected",
             results_seen, bad_results);
    if (bad_results == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bdq_datapath.sv
hw/rtl/bounded_deque_top.sv
tb/sv/tb_top.sv
